// File: design/pos_pkg.sv
// shared types, constants and helpers for the pyramid occupancy score block
`default_nettype none
package pos_pkg;

  // fixed field widths
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIM_W     = 16;
  localparam int unsigned CLVL_W    = 3;
  localparam int unsigned SCORE_W   = 13;
  localparam int unsigned DROP_W    = 16;
  localparam int unsigned LVL_W     = 5;
  localparam int unsigned LVX_W     = 6;

  // saturation limits
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [DROP_W-1:0]  DROP_MAX  = {DROP_W{1'b1}};

  // register reset values
  localparam logic [DIM_W-1:0]  MAX_DIM_RST      = 16'd4096;
  localparam logic [CLVL_W-1:0] COUNT_LEVELS_RST = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIM      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LEVELS = 2'd1;

  // per-level control from the top level to one occupancy slot
  typedef struct packed {
    logic take;   // a point marks this level, read its row now
    logic clear;  // the set ends at this edge
  } pos_ctl_t;

  // smallest t with 2^t >= dim, 0 for dim 0 or 1
  function automatic logic [LVL_W-1:0] top_level(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] d;
    logic [LVL_W-1:0] t;
    d = dim - DIM_W'(1);
    t = '0;
    if (dim > DIM_W'(1)) begin
      for (int i = 0; i < DIM_W; i++) begin
        if (d[i]) begin
          t = LVL_W'(i + 1);
        end
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: design/pos_slot.sv
// occupancy bitmap and distinct cell count of one relative pyramid level
`default_nettype none
module pos_slot
  import pos_pkg::*;
#(
  parameter int unsigned SIDE  = 6,
  parameter int unsigned CNT_W = 13
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pos_ctl_t          ctl,
  input  wire logic [((SIDE > 0) ? SIDE : 1)-1:0] rd_row,
  input  wire logic [((SIDE > 0) ? SIDE : 1)-1:0] rd_col,
  output logic      [CNT_W-1:0]  cnt_nxt
);

  localparam int unsigned IDX_W = (SIDE > 0) ? SIDE : 1;
  localparam int unsigned ROWS  = 1 << SIDE;
  localparam int unsigned WORD  = 1 << SIDE;

  // row memory, one bit per cell
  logic [WORD-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld_r;

  logic             act_r;
  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] col_r;
  logic [WORD-1:0]  rd_word_r;
  logic             vld_r;
  logic             byp_r;
  logic [WORD-1:0]  byp_word_r;
  logic [CNT_W-1:0] count_r;

  logic [WORD-1:0]  base;
  logic [WORD-1:0]  wr_word;
  logic             hit;
  logic             wr;

  // current row contents: forwarded write, stored row, or empty
  always_comb begin
    if (byp_r) begin
      base = byp_word_r;
    end else if (vld_r) begin
      base = rd_word_r;
    end else begin
      base = '0;
    end
    hit     = base[col_r[$clog2(WORD > 1 ? WORD : 2)-1:0] & ($clog2(WORD > 1 ? WORD : 2))'(WORD - 1)];
    wr      = act_r && !hit;
    wr_word = base | (WORD'(1) << col_r);
  end

  assign cnt_nxt = count_r + CNT_W'(wr);

  // row read at acceptance, with forwarding from the write at the same edge
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rd_word_r  <= mem[rd_row];
      row_r      <= rd_row;
      col_r      <= rd_col;
      vld_r      <= row_vld_r[rd_row] && !ctl.clear;
      byp_r      <= wr && (row_r == rd_row) && !ctl.clear;
      byp_word_r <= wr_word;
    end
  end

  // marking write
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[row_r] <= wr_word;
    end
  end

  // control state: active flag, row valid bits and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      row_vld_r <= '0;
      count_r   <= '0;
    end else begin
      act_r <= ctl.take;
      if (ctl.clear) begin
        row_vld_r <= '0;
        count_r   <= '0;
      end else begin
        if (wr) begin
          row_vld_r[row_r] <= 1'b1;
        end
        count_r <= cnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/pyramid_occupancy_score_top.sv
// top level of the pyramid occupancy score block
//
//   channel  ports                                        handshake
//   in       in_x_coord in_y_coord in_last_point          start / busy
//   out      out_score out_dropped_points                 out_valid strobe
//   cfg      cfg_index cfg_wdata                          cfg_valid / cfg_ready
//
// one point is taken every clock; busy never rises
// a point's row reads happen at the accepting edge; the marking write, the count
// update and, for a last point, the load of the result register that strobes
// out_valid all happen together at the next edge
// reset (rst_n low, synchronous) clears row valid bits, counts and the drop count
// the receiver cannot stall; cfg_ready is always high
`default_nettype none
module pyramid_occupancy_score_top
  import pos_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [COORD_W-1:0]   in_x_coord,
  input  wire logic [COORD_W-1:0]   in_y_coord,
  input  wire logic                 in_last_point,
  output logic                      out_valid,
  output logic      [SCORE_W-1:0]   out_score,
  output logic      [DROP_W-1:0]    out_dropped_points,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_wdata
);

  localparam int unsigned NSLOT = MAX_LEVELS + 1;
  localparam int unsigned CNT_W = 2 * MAX_LEVELS + 1;
  localparam int unsigned SUM_W = CNT_W + MAX_LEVELS + 4;
  localparam int unsigned CL_W  = $clog2(MAX_LEVELS + 1);

  logic [DIM_W-1:0]  max_dim_r;
  logic [CLVL_W-1:0] count_levels_r;

  logic              accept;
  logic              inb;
  logic [LVL_W-1:0]  top;
  logic [CL_W-1:0]   clamp;
  logic [LVL_W-1:0]  low;

  logic              s2_vld_r;
  logic              s2_last_r;
  logic              s2_drop_r;
  logic [DROP_W-1:0] drop_r;
  logic [DROP_W-1:0] drop_nxt;
  logic              set_end;

  logic [CNT_W-1:0]  cnt_nxt [NSLOT];
  logic [SUM_W-1:0]  sum;

  logic              out_valid_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [DROP_W-1:0] out_drop_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r      <= MAX_DIM_RST;
      count_levels_r <= COUNT_LEVELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_DIM:      max_dim_r      <= cfg_wdata;
        CFG_COUNT_LEVELS: count_levels_r <= cfg_wdata[CLVL_W-1:0];
        default: ;
      endcase
    end
  end

  // level range and bounds check for the point being accepted
  always_comb begin
    inb = (in_x_coord < max_dim_r) && (in_y_coord < max_dim_r);
    top = top_level(max_dim_r);
    if (32'(count_levels_r) > MAX_LEVELS) begin
      clamp = CL_W'(MAX_LEVELS);
    end else begin
      clamp = CL_W'(count_levels_r);
    end
    if (32'(top) > 32'(clamp) + 1) begin
      low = top - LVL_W'(clamp);
    end else begin
      low = LVL_W'(1);
    end
  end

  // one occupancy slot per relative level
  for (genvar k = 0; k < NSLOT; k++) begin : g_slot
    localparam int unsigned SIDE  = MAX_LEVELS - k;
    localparam int unsigned IDX_W = (SIDE > 0) ? SIDE : 1;

    logic [LVX_W-1:0]   lv;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    pos_ctl_t           ctl;

    always_comb begin
      lv       = LVX_W'(low) + LVX_W'(k);
      xs       = in_x_coord >> lv;
      ys       = in_y_coord >> lv;
      row      = (SIDE > 0) ? ys[IDX_W-1:0] : '0;
      col      = (SIDE > 0) ? xs[IDX_W-1:0] : '0;
      ctl.take  = accept && inb && (lv <= LVX_W'(top));
      ctl.clear = set_end;
    end

    pos_slot #(
      .SIDE  (SIDE),
      .CNT_W (CNT_W)
    ) u_slot (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .rd_row  (row),
      .rd_col  (col),
      .cnt_nxt (cnt_nxt[k])
    );
  end

  // mark stage bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_last_r <= in_last_point;
      s2_drop_r <= !inb;
    end
  end

  assign set_end = s2_vld_r && s2_last_r;

  // saturating drop count
  always_comb begin
    drop_nxt = drop_r;
    if (s2_vld_r && s2_drop_r && (drop_r != DROP_MAX)) begin
      drop_nxt = drop_r + DROP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= '0;
    end else if (set_end) begin
      drop_r <= '0;
    end else begin
      drop_r <= drop_nxt;
    end
  end

  // weighted score over levels holding more than one cell
  always_comb begin
    sum = '0;
    for (int k = 0; k < NSLOT; k++) begin
      if (cnt_nxt[k] > CNT_W'(1)) begin
        sum = sum + (SUM_W'(cnt_nxt[k]) << k);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= set_end;
    end
  end

  always_ff @(posedge clk) begin
    if (set_end) begin
      out_score_r <= (sum > SUM_W'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
      out_drop_r  <= drop_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_score          = out_score_r;
  assign out_dropped_points = out_drop_r;

endmodule
`default_nettype wire
